@@ hdl/bin_frame_deframer_defines.svh @@
// Assertion macros shared by the deframer checkers.
`ifndef BIN_FRAME_DEFRAMER_DEFINES_SVH
`define BIN_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bfd_pkg.sv @@
// Types and constants for the $BIN frame deframer.
package bfd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 1024;

  localparam int unsigned BC_W = 17;

  // "$BIN" header bytes
  localparam logic [7:0]  HDR_B0 = 8'h24;
  localparam logic [7:0]  HDR_B1 = 8'h42;
  localparam logic [7:0]  HDR_B2 = 8'h49;
  localparam logic [7:0]  HDR_B3 = 8'h4E;
  localparam logic [23:0] HDR_WIN = {HDR_B0, HDR_B1, HDR_B2};

  localparam logic [15:0] ID_MIN = 16'h001F;
  localparam logic [15:0] ID_MAX = 16'h0024;

  localparam logic [15:0] TRAILER = 16'h0D0A;

  // byte positions within a frame
  localparam logic [BC_W-1:0] POS_HDR_FULL = 17'd3;
  localparam logic [BC_W-1:0] POS_ID_LO    = 17'd4;
  localparam logic [BC_W-1:0] POS_ID_HI    = 17'd5;
  localparam logic [BC_W-1:0] POS_LEN_LO   = 17'd6;
  localparam logic [BC_W-1:0] POS_LEN_HI   = 17'd7;
  localparam logic [BC_W-1:0] POS_BODY     = 17'd8;
  localparam logic [BC_W-1:0] FRAME_OVERHEAD = 17'd12;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ID,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY        = 3'd0,
    ST_GOOD        = 3'd1,
    ST_BAD_ID      = 3'd2,
    ST_BAD_TRAILER = 3'd3,
    ST_BAD_SUM     = 3'd4,
    ST_TOO_LONG    = 3'd5
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [5:0] frame_id;
  } res_t;

endpackage

@@ hdl/bfd_in_reg.sv @@
// Input register stage: holds one received byte until the parser takes it.
module bfd_in_reg import bfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       adv,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || adv;
  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

@@ hdl/bfd_core.sv @@
// Frame parser: state registers and the per-byte next-state logic.
module bfd_core import bfd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [7:0] rx_byte,
  output res_t       res_nxt
);

  phase_t            phase_r, phase_nxt;
  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic [23:0]       win_r, win_nxt;
  logic [15:0]       id_r, id_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [15:0]       sum_r, sum_nxt;
  logic [15:0]       chk_r, chk_nxt;
  logic [15:0]       last_r, last_nxt;

  logic [15:0]       len_full;
  logic [BC_W-1:0]   len_ext;
  logic [BC_W-1:0]   chk_pos;
  logic [BC_W-1:0]   bc_inc;

  assign len_full = {rx_byte, len_r[7:0]};
  assign len_ext  = {1'b0, len_r};
  assign chk_pos  = len_ext + POS_BODY;
  assign bc_inc   = bc_r + 17'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      bc_r    <= '0;
      win_r   <= '0;
      id_r    <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      chk_r   <= '0;
      last_r  <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      win_r   <= win_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      chk_r   <= chk_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    win_nxt   = win_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    chk_nxt   = chk_r;
    last_nxt  = last_r;
    res_nxt.status   = ST_BUSY;
    res_nxt.frame_id = '0;

    unique case (phase_r)
      PH_HUNT: begin
        if (bc_r >= POS_HDR_FULL && win_r == HDR_WIN && rx_byte == HDR_B3) begin
          phase_nxt = PH_ID;
          bc_nxt    = POS_ID_LO;
          win_nxt   = '0;
        end else begin
          win_nxt = {win_r[15:0], rx_byte};
          bc_nxt  = (bc_r < POS_HDR_FULL) ? bc_inc : POS_HDR_FULL;
        end
      end
      PH_ID: begin
        if (bc_r == POS_ID_LO) begin
          id_nxt = {8'h00, rx_byte};
          bc_nxt = POS_ID_HI;
        end else begin
          id_nxt    = {rx_byte, id_r[7:0]};
          bc_nxt    = POS_LEN_LO;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        if (bc_r == POS_LEN_LO) begin
          len_nxt = {8'h00, rx_byte};
          bc_nxt  = POS_LEN_HI;
        end else begin
          len_nxt = len_full;
          if (id_r < ID_MIN || id_r > ID_MAX) begin
            res_nxt.status = ST_BAD_ID;
            phase_nxt = PH_HUNT;
            bc_nxt    = '0;
            win_nxt   = '0;
          end else if (len_full > 16'(MAX_PAYLOAD)) begin
            res_nxt.status = ST_TOO_LONG;
            phase_nxt = PH_HUNT;
            bc_nxt    = '0;
            win_nxt   = '0;
          end else begin
            bc_nxt    = POS_BODY;
            sum_nxt   = '0;
            chk_nxt   = '0;
            last_nxt  = '0;
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        bc_nxt = bc_inc;
        if (bc_r < chk_pos) begin
          sum_nxt = sum_r + {8'h00, rx_byte};
        end else if (bc_r == chk_pos) begin
          chk_nxt = {chk_r[15:8], rx_byte};
        end else if (bc_r == chk_pos + 17'd1) begin
          chk_nxt = {rx_byte, chk_r[7:0]};
        end
        last_nxt = {last_r[7:0], rx_byte};
        // frame ends on the LF byte, i.e. byte position L+11 of the frame
        if (bc_inc >= len_ext + FRAME_OVERHEAD) begin
          if (last_nxt != TRAILER) begin
            res_nxt.status = ST_BAD_TRAILER;
          end else if (chk_nxt != sum_nxt) begin
            res_nxt.status = ST_BAD_SUM;
          end else begin
            res_nxt.status   = ST_GOOD;
            res_nxt.frame_id = id_r[5:0];
          end
          phase_nxt = PH_HUNT;
          bc_nxt    = '0;
          win_nxt   = '0;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        bc_nxt    = '0;
        win_nxt   = '0;
      end
    endcase
  end

endmodule

@@ hdl/bfd_out_reg.sv @@
// Result register: holds one status until the consumer takes it.
module bfd_out_reg import bfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       res_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [5:0] out_frame_id
);

  logic valid_r;
  res_t res_r;

  assign out_valid    = valid_r;
  assign out_status   = res_r.status;
  assign out_frame_id = res_r.frame_id;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

@@ hdl/bin_frame_deframer.sv @@
// Top level of the $BIN frame deframer.
// Takes one received byte per transfer and returns one status per byte: busy or
// hunting, good frame (with ID bits 5:0), bad ID, bad trailer, bad checksum
// or too long. A byte passes through an input register and the parser into a
// result register, which holds each result until the consumer takes it. The block
// sustains one byte per clock; only back-pressure on the result side slows it.
// The payload is never stored, only summed, so there is no memory and no
// start-up sweep after reset. MAX_PAYLOAD sets the largest accepted length.
module bin_frame_deframer import bfd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [5:0] out_frame_id
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       adv;
  res_t       res_nxt;

  // move the held byte on when the result register is free or being emptied
  assign adv = s1_valid && (!out_valid || out_ready);

  bfd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .adv        (adv),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte)
  );

  bfd_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .rx_byte (s1_byte),
    .res_nxt (res_nxt)
  );

  bfd_out_reg u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (adv),
    .res_in       (res_nxt),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_frame_id (out_frame_id)
  );

endmodule

@@ hdl/bfd_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
`include "bin_frame_deframer_defines.svh"

module bfd_checker import bfd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [5:0] out_frame_id
);

  `BFD_ASSERT_IMP(a_id_only_good, out_valid && out_status != ST_GOOD, out_frame_id == 6'd0, "frame id set on a non-good status")
  `BFD_ASSERT_IMP(a_good_id_range, out_valid && out_status == ST_GOOD, out_frame_id >= ID_MIN[5:0] && out_frame_id <= ID_MAX[5:0], "good frame with id out of range")
  `BFD_ASSERT_IMP(a_no_stall_on_drain, out_valid && out_ready, in_ready, "input stalled while result drains")
  `BFD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_frame_id), "stalled result changed")

endmodule

bind bin_frame_deframer bfd_checker u_bfd_checker (.*);

@@ verif/tb_bin_frame_deframer.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the $BIN frame deframer: byte stream in, status per byte out.
module tb_bin_frame_deframer;
  import bfd_pkg::*;

  typedef enum int {
    FLT_NONE,
    FLT_SUM,
    FLT_CR,
    FLT_LF,
    FLT_CUT
  } frame_fault_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_status;
  logic [5:0] out_frame_id;

  // deframer shadow state
  phase_t      hunt_phase;
  logic [16:0] frame_pos;
  logic [23:0] hdr_window;
  logic [15:0] id_field;
  logic [15:0] len_field;
  logic [15:0] body_sum;
  logic [15:0] sent_sum;
  logic [15:0] tail_bytes;

  res_t        expected_status_q[$];
  logic [7:0]  frame_bytes[$];
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  bit          src_burst = 1'b0;
  bit          sink_burst = 1'b0;
  int unsigned sink_hold = 0;

  bin_frame_deframer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_frame_id(out_frame_id)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic reset_deframer_state();
    hunt_phase = PH_HUNT;
    frame_pos  = '0;
    hdr_window = '0;
    id_field   = '0;
    len_field  = '0;
    body_sum   = '0;
    sent_sum   = '0;
    tail_bytes = '0;
  endtask

  function automatic void back_to_hunt();
    hunt_phase = PH_HUNT;
    frame_pos  = '0;
    hdr_window = '0;
  endfunction

  // Advances the shadow deframer by one byte and returns the status it reports.
  function automatic res_t deframe_byte(input logic [7:0] b);
    res_t        r;
    int unsigned at;
    int unsigned body_end;
    r.status   = ST_BUSY;
    r.frame_id = '0;
    body_end   = int'(len_field) + 8;
    case (hunt_phase)
      PH_HUNT: begin
        if (frame_pos >= POS_HDR_FULL && hdr_window == HDR_WIN && b == HDR_B3) begin
          hunt_phase = PH_ID;
          frame_pos  = POS_ID_LO;
          hdr_window = '0;
        end else begin
          hdr_window = {hdr_window[15:0], b};
          frame_pos  = (frame_pos < POS_HDR_FULL) ? frame_pos + 17'd1 : POS_HDR_FULL;
        end
      end
      PH_ID: begin
        if (frame_pos == POS_ID_LO) begin
          id_field  = {8'h00, b};
          frame_pos = POS_ID_HI;
        end else begin
          id_field   = {b, id_field[7:0]};
          frame_pos  = POS_LEN_LO;
          hunt_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (frame_pos == POS_LEN_LO) begin
          len_field = {8'h00, b};
          frame_pos = POS_LEN_HI;
        end else begin
          len_field = {b, len_field[7:0]};
          if (id_field < ID_MIN || id_field > ID_MAX) begin
            r.status = ST_BAD_ID;
            back_to_hunt();
          end else if (int'(len_field) > int'(MAX_PAYLOAD_DEF)) begin
            r.status = ST_TOO_LONG;
            back_to_hunt();
          end else begin
            frame_pos  = POS_BODY;
            body_sum   = '0;
            sent_sum   = '0;
            tail_bytes = '0;
            hunt_phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        at        = frame_pos;
        frame_pos = frame_pos + 17'd1;
        if (at < body_end) body_sum = body_sum + {8'h00, b};
        else if (at == body_end) sent_sum[7:0] = b;
        else if (at == body_end + 1) sent_sum[15:8] = b;
        tail_bytes = {tail_bytes[7:0], b};
        if (int'(frame_pos) >= int'(len_field) + int'(FRAME_OVERHEAD)) begin
          if (tail_bytes != TRAILER) r.status = ST_BAD_TRAILER;
          else if (sent_sum != body_sum) r.status = ST_BAD_SUM;
          else begin
            r.status   = ST_GOOD;
            r.frame_id = id_field[5:0];
          end
          back_to_hunt();
        end
      end
      default: back_to_hunt();
    endcase
    return r;
  endfunction

  // Result side: random stalls with occasional stretches of full throughput.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) sink_burst = !sink_burst;
    if (sink_hold != 0) begin
      out_ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else if (sink_burst || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      sink_hold = pick_gap() - 1;
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_status_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: status %0d id %0d",
                 $time, out_status, out_frame_id);
      end else begin
        want = expected_status_q.pop_front();
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
        if (out_frame_id !== want.frame_id) begin
          errors++;
          $display("%0t: frame_id expected %0d actual %0d",
                   $time, want.frame_id, out_frame_id);
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (!src_burst && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_status_q.push_back(deframe_byte(b));
    bytes_sent++;
  endtask

  task automatic push_frame_bytes(input int unsigned first, input int unsigned last);
    for (int unsigned i = first; i < last; i++) push_byte(frame_bytes[i]);
  endtask

  // Stops sending until every status has come back, then holds off a little longer.
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat ($urandom_range(3, 30)) @(posedge clk);
  endtask

  // Fills frame_bytes with one frame; the body is only added when id and length pass.
  task automatic build_frame(input logic [15:0] id, input logic [15:0] len,
                             input frame_fault_t fault, input bit all_ff);
    logic [15:0] sum;
    logic [7:0]  b;
    int unsigned keep;
    frame_bytes.delete();
    sum = '0;
    frame_bytes.push_back(HDR_B0);
    frame_bytes.push_back(HDR_B1);
    frame_bytes.push_back(HDR_B2);
    frame_bytes.push_back(HDR_B3);
    frame_bytes.push_back(id[7:0]);
    frame_bytes.push_back(id[15:8]);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    if (id < ID_MIN || id > ID_MAX || int'(len) > int'(MAX_PAYLOAD_DEF)) return;
    for (int unsigned i = 0; i < len; i++) begin
      b = all_ff ? 8'hFF : 8'($urandom);
      sum = sum + {8'h00, b};
      frame_bytes.push_back(b);
    end
    if (fault == FLT_SUM) sum = sum ^ (16'h1 << $urandom_range(0, 15));
    frame_bytes.push_back(sum[7:0]);
    frame_bytes.push_back(sum[15:8]);
    b = TRAILER[15:8];
    if (fault == FLT_CR) while (b == TRAILER[15:8]) b = 8'($urandom);
    frame_bytes.push_back(b);
    b = TRAILER[7:0];
    if (fault == FLT_LF) while (b == TRAILER[7:0]) b = 8'($urandom);
    frame_bytes.push_back(b);
    if (fault == FLT_CUT) begin
      keep = 8 + $urandom_range(0, len + 3);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end
  endtask

  task automatic send_frame(input logic [15:0] id, input logic [15:0] len,
                            input frame_fault_t fault);
    build_frame(id, len, fault, 1'b0);
    push_frame_bytes(0, frame_bytes.size());
  endtask

  // Partial headers, a mismatch inside the header and bytes at both extremes.
  task automatic test_header_hunt();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(HDR_B0);
    push_byte(HDR_B1);
    push_byte(HDR_B2);
    push_byte(HDR_B0);
    push_byte(HDR_B1);
    push_byte(HDR_B2);
    push_byte(HDR_B3);
    push_byte(8'h1F);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(TRAILER[15:8]);
    push_byte(TRAILER[7:0]);
  endtask

  task automatic test_id_and_length();
    send_frame(16'h001E, 16'h0000, FLT_NONE);
    send_frame(16'h0025, 16'h0003, FLT_NONE);
    send_frame(16'h0124, 16'hFFFF, FLT_NONE);   // bad id wins over too long
    send_frame(16'h0024, 16'h0401, FLT_NONE);
  endtask

  task automatic test_frame_ends();
    send_frame(16'h0024, 16'h0000, FLT_NONE);
    send_frame(16'h0020, 16'h0002, FLT_CR);
    send_frame(16'h0021, 16'h0002, FLT_LF);
    send_frame(16'h0022, 16'h0002, FLT_SUM);
  endtask

  // Longest legal payload, all ones, so the running sum wraps several times.
  task automatic test_max_payload();
    build_frame(16'h001F, 16'(MAX_PAYLOAD_DEF), FLT_NONE, 1'b1);
    push_frame_bytes(0, frame_bytes.size());
  endtask

  task automatic test_drain_pause();
    build_frame(16'h0023, 16'h0005, FLT_NONE, 1'b0);
    push_frame_bytes(0, 10);
    hold_until_drained();
    push_frame_bytes(10, frame_bytes.size());
  endtask

  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned   target;
    int unsigned   r;
    int unsigned   n;
    logic [15:0]   id;
    logic [15:0]   len;
    frame_fault_t  fault;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 9) == 0) src_burst = !src_burst;
      r   = $urandom_range(0, 99);
      id  = 16'($urandom_range(ID_MIN, ID_MAX));
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(17, 100))
                                        : 16'($urandom_range(0, 16));
      fault = FLT_NONE;
      if (r < 94) begin
        if (r >= 70 && r < 78) fault = FLT_SUM;
        else if (r >= 78 && r < 81) fault = FLT_CR;
        else if (r >= 81 && r < 84) fault = FLT_LF;
        else if (r >= 84 && r < 88) begin
          id = 16'($urandom);
          if (id >= ID_MIN && id <= ID_MAX) id[15:8] = 8'($urandom_range(1, 255));
        end else if (r >= 88 && r < 91) len = 16'($urandom_range(MAX_PAYLOAD_DEF + 1, 65535));
        else if (r >= 91) fault = FLT_CUT;
        send_frame(id, len, fault);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0: push_byte(HDR_B0);
            1: push_byte(HDR_B1);
            2: push_byte(HDR_B2);
            default: push_byte(8'($urandom));
          endcase
        end
      end
      if ($urandom_range(0, 39) == 0) hold_until_drained();
    end
  endtask

  initial begin
    int unsigned waited;
    reset_deframer_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_header_hunt();
    test_id_and_length();
    test_frame_ends();
    test_drain_pause();
    test_max_payload();
    test_random_traffic(550);

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_status_q.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_status_q.size() != 0) begin
      errors++;
      $display("%0t: %0d statuses expected but never returned",
               $time, expected_status_q.size());
    end
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
